// File: rtl/tspnn_pkg.sv
// Shared widths, command codes and the controller/datapath link structs
// for the nearest-neighbour plus 2-opt tour search. No dependencies.
`timescale 1ns / 1ps
package tspnn_pkg;

   localparam int MAX_CITIES = 128;
   localparam int CITY_W     = $clog2(MAX_CITIES);
   localparam int CNT_W      = $clog2(MAX_CITIES + 1);
   localparam int DIST_W     = 24;
   localparam int LEN_W      = 31;
   localparam int DADDR_W    = 2 * CITY_W;
   localparam int TOUR_DEPTH = MAX_CITIES + 1;
   localparam int TADDR_W    = $clog2(TOUR_DEPTH);

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_code_type;

   // one strobe per datapath action
   typedef struct packed {
      logic wr_first;
      logic wr_second;
      logic rd_issue;
      logic rd_reply;
      logic bad_reply;
      logic nn_init;
      logic nn_scan;
      logic nn_pick;
      logic nn_fin;
      logic len_t;
      logic len_d;
      logic len_a;
      logic len_end;
      logic opt_ni;
      logic opt_t1;
      logic opt_t2;
      logic opt_d0;
      logic opt_d1;
      logic opt_d2;
      logic opt_d3;
      logic opt_d4;
      logic opt_adv;
      logic rev_rd;
      logic rev_w1;
      logic rev_w2;
      logic done_reply;
   } cmd_type;

   typedef struct packed {
      logic start_bad;
      logic scan_last;
      logic nn_more;
      logic len_more;
      logic len_first;
      logic len_same;
      logic pass_done;
      logic j_ok;
      logic adv_more;
      logic better;
      logic rev_more;
   } stat_type;

endpackage

// File: rtl/tspnn_ctrl.sv
// Sequencer for the tour search: one-hot state machine issuing datapath actions.
// Depends on tspnn_pkg.
`timescale 1ns / 1ps
module tspnn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_command,
   input  tspnn_pkg::stat_type  stat,
   output tspnn_pkg::cmd_type   cmd,
   output logic                 busy
);
   import tspnn_pkg::*;

   typedef enum logic [24:0] {
      S_IDLE    = 25'h0000001,
      S_WR2     = 25'h0000002,
      S_READ    = 25'h0000004,
      S_NN_SCAN = 25'h0000008,
      S_NN_LAST = 25'h0000010,
      S_NN_PICK = 25'h0000020,
      S_NN_FIN  = 25'h0000040,
      S_LEN_T   = 25'h0000080,
      S_LEN_D   = 25'h0000100,
      S_LEN_A   = 25'h0000200,
      S_LEN_END = 25'h0000400,
      S_OPT_NI  = 25'h0000800,
      S_OPT_T1  = 25'h0001000,
      S_OPT_T2  = 25'h0002000,
      S_OPT_D0  = 25'h0004000,
      S_OPT_D1  = 25'h0008000,
      S_OPT_D2  = 25'h0010000,
      S_OPT_D3  = 25'h0020000,
      S_OPT_D4  = 25'h0040000,
      S_OPT_ADV = 25'h0080000,
      S_REV_RD  = 25'h0100000,
      S_REV_W1  = 25'h0200000,
      S_REV_W2  = 25'h0400000,
      S_DONE    = 25'h0800000,
      S_SPARE   = 25'h1000000
   } state_type;

   state_type    state_ff, state_in;
   logic         fire;
   cmd_code_type code;

   assign code = cmd_code_type'(req_command);
   assign busy = (state_ff != S_IDLE);
   assign fire = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (fire) begin
               case (code)
                  CMD_WRITE: begin
                     cmd.wr_first = 1'b1;
                     state_in     = S_WR2;
                  end
                  CMD_READ: begin
                     cmd.rd_issue = 1'b1;
                     state_in     = S_READ;
                  end
                  CMD_RUN: begin
                     if (stat.start_bad) begin
                        cmd.bad_reply = 1'b1;
                     end else begin
                        cmd.nn_init = 1'b1;
                        state_in    = S_NN_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_WR2: begin
            cmd.wr_second = 1'b1;
            state_in      = S_IDLE;
         end
         S_READ: begin
            cmd.rd_reply = 1'b1;
            state_in     = S_IDLE;
         end
         S_NN_SCAN: begin
            cmd.nn_scan = 1'b1;
            if (stat.scan_last) state_in = S_NN_LAST;
         end
         S_NN_LAST: state_in = S_NN_PICK;
         S_NN_PICK: begin
            cmd.nn_pick = 1'b1;
            state_in    = stat.nn_more ? S_NN_SCAN : S_NN_FIN;
         end
         S_NN_FIN: begin
            cmd.nn_fin = 1'b1;
            state_in   = S_LEN_T;
         end
         S_LEN_T: begin
            cmd.len_t = 1'b1;
            state_in  = S_LEN_D;
         end
         S_LEN_D: begin
            cmd.len_d = 1'b1;
            state_in  = S_LEN_A;
         end
         S_LEN_A: begin
            cmd.len_a = 1'b1;
            state_in  = stat.len_more ? S_LEN_T : S_LEN_END;
         end
         S_LEN_END: begin
            cmd.len_end = 1'b1;
            state_in    = (stat.len_first || !stat.len_same) ? S_OPT_NI : S_DONE;
         end
         S_OPT_NI: begin
            cmd.opt_ni = 1'b1;
            if (stat.pass_done) state_in = S_LEN_T;
            else if (stat.j_ok) state_in = S_OPT_T1;
         end
         S_OPT_T1: begin
            cmd.opt_t1 = 1'b1;
            state_in   = S_OPT_T2;
         end
         S_OPT_T2: begin
            cmd.opt_t2 = 1'b1;
            state_in   = S_OPT_D0;
         end
         S_OPT_D0: begin
            cmd.opt_d0 = 1'b1;
            state_in   = S_OPT_D1;
         end
         S_OPT_D1: begin
            cmd.opt_d1 = 1'b1;
            state_in   = S_OPT_D2;
         end
         S_OPT_D2: begin
            cmd.opt_d2 = 1'b1;
            state_in   = S_OPT_D3;
         end
         S_OPT_D3: begin
            cmd.opt_d3 = 1'b1;
            state_in   = S_OPT_D4;
         end
         S_OPT_D4: begin
            cmd.opt_d4 = 1'b1;
            state_in   = stat.better ? S_REV_RD : S_OPT_ADV;
         end
         S_OPT_ADV: begin
            cmd.opt_adv = 1'b1;
            state_in    = stat.adv_more ? S_OPT_T1 : S_OPT_NI;
         end
         S_REV_RD: begin
            cmd.rev_rd = 1'b1;
            state_in   = stat.rev_more ? S_REV_W1 : S_OPT_ADV;
         end
         S_REV_W1: begin
            cmd.rev_w1 = 1'b1;
            state_in   = S_REV_W2;
         end
         S_REV_W2: begin
            cmd.rev_w2 = 1'b1;
            state_in   = S_REV_RD;
         end
         S_DONE: begin
            cmd.done_reply = 1'b1;
            state_in       = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: rtl/tspnn_dpath.sv
// Datapath: distance and tour memories, visited bits, counters, sums and
// the registered reply. Depends on tspnn_pkg; driven by tspnn_ctrl.
`timescale 1ns / 1ps
module tspnn_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  tspnn_pkg::cmd_type              cmd,
   output tspnn_pkg::stat_type             stat,
   input  logic [tspnn_pkg::CITY_W-1:0]    req_row_city,
   input  logic [tspnn_pkg::CITY_W-1:0]    req_col_city,
   input  logic [tspnn_pkg::DIST_W-1:0]    req_distance,
   input  logic [tspnn_pkg::CITY_W-1:0]    req_start_city,
   input  logic [tspnn_pkg::CITY_W-1:0]    req_position,
   input  logic                            csr_write_enable,
   input  logic [7:0]                      csr_write_data,
   output logic                            rsp_strobe,
   output logic [tspnn_pkg::CITY_W-1:0]    rsp_city,
   output logic [tspnn_pkg::LEN_W-1:0]     rsp_tour_length,
   output logic                            rsp_status
);
   import tspnn_pkg::*;

   // memories
   logic [DIST_W-1:0] dist_mem [0:(1 << DADDR_W)-1];
   logic [CITY_W-1:0] tour_mem [0:TOUR_DEPTH-1];

   logic [7:0]         cities_ff;
   logic [CNT_W-1:0]   n;
   logic [MAX_CITIES-1:0] visited_ff;
   logic [CNT_W-1:0]   tour_cities_ff;
   logic [LEN_W-1:0]   last_len_ff;

   logic [CITY_W-1:0]  row_ff, col_ff;
   logic [DIST_W-1:0]  wdist_ff;
   logic [CITY_W-1:0]  start_ff, cur_ff, best_ff;
   logic [DIST_W-1:0]  best_d_ff;
   logic               found_ff, cmp_valid_ff;
   logic [CITY_W-1:0]  cmp_c_ff;
   logic [CNT_W-1:0]   c_ff, k_ff, i_ff, j_ff;
   logic [TADDR_W-1:0] lo_ff, hi_ff;
   logic [LEN_W-1:0]   acc_ff, prev_ff;
   logic               first_ff, pos_ok_ff;
   logic [CITY_W-1:0]  a_ff, b_ff, c2_ff, d_ff;
   logic [DIST_W:0]    now_ff, alt_ff;

   logic               d_we, d_re, t_we, t_re;
   logic [DADDR_W-1:0] d_waddr, d_raddr;
   logic [DIST_W-1:0]  d_wdata, d_rdata_ff;
   logic [TADDR_W-1:0] t_waddr, t_ra0, t_ra1;
   logic [CITY_W-1:0]  t_wdata, t_rd0_ff, t_rd1_ff;
   logic [CNT_W-1:0]   end_i;
   logic [DIST_W:0]    alt_sum;

   // clamp the city count to 2..MAX_CITIES
   always_comb begin
      if (cities_ff < 8'd2) n = CNT_W'(2);
      else if (cities_ff > 8'(MAX_CITIES)) n = CNT_W'(MAX_CITIES);
      else n = CNT_W'(cities_ff);
   end

   assign end_i   = (i_ff == '0) ? n - CNT_W'(1) : n;
   assign alt_sum = alt_ff + {1'b0, d_rdata_ff};

   always_comb begin
      stat.start_bad = CNT_W'(req_start_city) >= n;
      stat.scan_last = (c_ff == n - CNT_W'(1));
      stat.nn_more   = (k_ff + CNT_W'(1)) < n;
      stat.len_more  = (k_ff + CNT_W'(1)) < n;
      stat.len_first = first_ff;
      stat.len_same  = (acc_ff == prev_ff);
      stat.pass_done = (i_ff + CNT_W'(1)) >= n;
      stat.j_ok      = (i_ff + CNT_W'(2)) < end_i;
      stat.adv_more  = (j_ff + CNT_W'(1)) < end_i;
      stat.better    = now_ff > alt_sum;
      stat.rev_more  = lo_ff < hi_ff;
   end

   // distance port selection
   always_comb begin
      d_we    = cmd.wr_first || cmd.wr_second;
      d_waddr = cmd.wr_first ? {req_row_city, req_col_city} : {col_ff, row_ff};
      d_wdata = cmd.wr_first ? req_distance : wdist_ff;
      d_re    = 1'b1;
      if (cmd.nn_scan)     d_raddr = {cur_ff, c_ff[CITY_W-1:0]};
      else if (cmd.len_d)  d_raddr = {t_rd0_ff, t_rd1_ff};
      else if (cmd.opt_d0) d_raddr = {a_ff, b_ff};
      else if (cmd.opt_d1) d_raddr = {c2_ff, d_ff};
      else if (cmd.opt_d2) d_raddr = {a_ff, c2_ff};
      else if (cmd.opt_d3) d_raddr = {b_ff, d_ff};
      else begin
         d_raddr = '0;
         d_re    = 1'b0;
      end
   end

   // tour port selection
   always_comb begin
      t_we    = 1'b1;
      t_waddr = '0;
      t_wdata = '0;
      if (cmd.nn_init) begin
         t_wdata = req_start_city;
      end else if (cmd.nn_pick) begin
         t_waddr = TADDR_W'(k_ff);
         t_wdata = best_ff;
      end else if (cmd.nn_fin) begin
         t_waddr = TADDR_W'(n);
         t_wdata = start_ff;
      end else if (cmd.rev_w1) begin
         t_waddr = lo_ff;
         t_wdata = t_rd1_ff;
      end else if (cmd.rev_w2) begin
         t_waddr = hi_ff;
         t_wdata = t_rd0_ff;
      end else begin
         t_we = 1'b0;
      end
      t_re  = 1'b1;
      t_ra0 = '0;
      t_ra1 = '0;
      if (cmd.rd_issue) begin
         t_ra0 = TADDR_W'(req_position);
      end else if (cmd.len_t) begin
         t_ra0 = TADDR_W'(k_ff);
         t_ra1 = TADDR_W'(k_ff + CNT_W'(1));
      end else if (cmd.opt_t1) begin
         t_ra0 = TADDR_W'(i_ff);
         t_ra1 = TADDR_W'(i_ff + CNT_W'(1));
      end else if (cmd.opt_t2) begin
         t_ra0 = TADDR_W'(j_ff);
         t_ra1 = TADDR_W'(j_ff + CNT_W'(1));
      end else if (cmd.rev_rd) begin
         t_ra0 = lo_ff;
         t_ra1 = hi_ff;
      end else begin
         t_re = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (d_we) dist_mem[d_waddr] <= d_wdata;
      if (d_re) d_rdata_ff <= dist_mem[d_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we) tour_mem[t_waddr] <= t_wdata;
      if (t_re) begin
         t_rd0_ff <= tour_mem[t_ra0];
         t_rd1_ff <= tour_mem[t_ra1];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cities_ff      <= 8'd2;
         visited_ff     <= '0;
         tour_cities_ff <= '0;
         last_len_ff    <= '0;
         rsp_strobe     <= 1'b0;
         found_ff       <= 1'b0;
         cmp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) cities_ff <= csr_write_data;
         rsp_strobe   <= cmd.rd_reply || cmd.bad_reply || cmd.done_reply;
         cmp_valid_ff <= cmd.nn_scan;
         // fresh run: only the start city is marked
         if (cmd.nn_init) visited_ff <= MAX_CITIES'(1) << req_start_city;
         if (cmd.nn_pick) visited_ff[best_ff] <= 1'b1;
         if (cmd.nn_init || cmd.nn_pick) begin
            found_ff <= 1'b0;
         end else if (cmp_valid_ff && !visited_ff[cmp_c_ff]
                      && (!found_ff || d_rdata_ff < best_d_ff)) begin
            found_ff <= 1'b1;
         end
         if (cmd.done_reply) begin
            last_len_ff    <= acc_ff;
            tour_cities_ff <= n;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmp_c_ff <= c_ff[CITY_W-1:0];
      if (cmd.wr_first) begin
         row_ff   <= req_row_city;
         col_ff   <= req_col_city;
         wdist_ff <= req_distance;
      end
      if (cmd.rd_issue) pos_ok_ff <= CNT_W'(req_position) < tour_cities_ff;
      if (cmd.nn_init) begin
         start_ff <= req_start_city;
         cur_ff   <= req_start_city;
         k_ff     <= CNT_W'(1);
      end
      if (cmd.nn_init || cmd.nn_pick) c_ff <= '0;
      else if (cmd.nn_scan) c_ff <= c_ff + CNT_W'(1);
      if (cmp_valid_ff && !visited_ff[cmp_c_ff]
          && (!found_ff || d_rdata_ff < best_d_ff)) begin
         best_ff   <= cmp_c_ff;
         best_d_ff <= d_rdata_ff;
      end
      if (cmd.nn_pick) begin
         cur_ff <= best_ff;
         k_ff   <= k_ff + CNT_W'(1);
      end
      if (cmd.nn_fin) begin
         k_ff     <= '0;
         acc_ff   <= '0;
         first_ff <= 1'b1;
      end
      if (cmd.len_a) begin
         acc_ff <= acc_ff + LEN_W'(d_rdata_ff);
         k_ff   <= k_ff + CNT_W'(1);
      end
      if (cmd.len_end) begin
         prev_ff  <= acc_ff;
         first_ff <= 1'b0;
         i_ff     <= '0;
      end
      if (cmd.opt_ni) begin
         if (stat.pass_done) begin
            k_ff   <= '0;
            acc_ff <= '0;
         end else if (stat.j_ok) begin
            j_ff <= i_ff + CNT_W'(2);
         end else begin
            i_ff <= i_ff + CNT_W'(1);
         end
      end
      if (cmd.opt_t2) begin
         a_ff <= t_rd0_ff;
         b_ff <= t_rd1_ff;
      end
      if (cmd.opt_d0) begin
         c2_ff <= t_rd0_ff;
         d_ff  <= t_rd1_ff;
      end
      if (cmd.opt_d1) now_ff <= {1'b0, d_rdata_ff};
      if (cmd.opt_d2) now_ff <= now_ff + {1'b0, d_rdata_ff};
      if (cmd.opt_d3) alt_ff <= {1'b0, d_rdata_ff};
      if (cmd.opt_d4) begin
         lo_ff <= TADDR_W'(i_ff + CNT_W'(1));
         hi_ff <= TADDR_W'(j_ff);
      end
      if (cmd.rev_w2) begin
         lo_ff <= lo_ff + TADDR_W'(1);
         hi_ff <= hi_ff - TADDR_W'(1);
      end
      if (cmd.opt_adv) begin
         if (stat.adv_more) j_ff <= j_ff + CNT_W'(1);
         else i_ff <= i_ff + CNT_W'(1);
      end
   end

   // reply payload
   always_ff @(posedge clock) begin
      if (cmd.rd_reply) begin
         rsp_city        <= pos_ok_ff ? t_rd0_ff : '0;
         rsp_tour_length <= last_len_ff;
         rsp_status      <= 1'b0;
      end else if (cmd.bad_reply) begin
         rsp_city        <= '0;
         rsp_tour_length <= '0;
         rsp_status      <= 1'b1;
      end else if (cmd.done_reply) begin
         rsp_city        <= '0;
         rsp_tour_length <= acc_ff;
         rsp_status      <= 1'b0;
      end
   end

endmodule

// File: rtl/tsp_nearest_neighbour_two_opt.sv
// Top level of the tour search: sequencer plus datapath.
// Depends on tspnn_pkg, tspnn_ctrl and tspnn_dpath.
`timescale 1ns / 1ps
// A beat is taken when start is high and busy is low. Results appear on the
// rsp_ ports for one cycle with rsp_strobe and cannot be held off, so the
// receiver must take them as they come. A distance write stores both
// directions through the single write port of the distance memory and
// gives no result. A read answers in the cycle in which busy drops. A run
// with a start city not below the clamped city count answers status 1 on
// the next cycle and does not go busy. A good run with n cities builds a
// nearest-neighbour tour (one distance read for every city in each scan),
// sums the tour length, and then makes 2-opt passes that try each (i, j)
// pair and reverse the segment between them when the swap is shorter;
// passes repeat until the length stops falling. The build, the sums and
// the passes all share the one distance-memory read port.
module tsp_nearest_neighbour_two_opt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_command,
   input  logic [tspnn_pkg::CITY_W-1:0]   req_row_city,
   input  logic [tspnn_pkg::CITY_W-1:0]   req_col_city,
   input  logic [tspnn_pkg::DIST_W-1:0]   req_distance,
   input  logic [tspnn_pkg::CITY_W-1:0]   req_start_city,
   input  logic [tspnn_pkg::CITY_W-1:0]   req_position,
   output logic                           rsp_strobe,
   output logic [tspnn_pkg::CITY_W-1:0]   rsp_city,
   output logic [tspnn_pkg::LEN_W-1:0]    rsp_tour_length,
   output logic                           rsp_status,
   input  logic                           csr_write_enable,
   input  logic [7:0]                     csr_write_data
);
   import tspnn_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: decodes the beat and steps through build, sums and passes
   tspnn_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   // memories, counters, compares and the reply register
   tspnn_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_row_city     (req_row_city),
      .req_col_city     (req_col_city),
      .req_distance     (req_distance),
      .req_start_city   (req_start_city),
      .req_position     (req_position),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_city         (rsp_city),
      .rsp_tour_length  (rsp_tour_length),
      .rsp_status       (rsp_status)
   );

endmodule
